/* hw/rtl/cee_pkg.sv */
// Shared definitions for the crease edge extractor: parameter defaults,
// field widths, opcodes and the status word of the normal dot-product unit.
// No dependencies.
`default_nettype none

package cee_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_FACES_DEF   = 1024;
  localparam int VERTEX_BITS_DEF = 16;
  localparam int NORMAL_BITS_DEF = 16;

  // Fixed port widths
  localparam int PORT_W = 16;  // vertex and normal fields on the ports
  localparam int THR_W  = 16;  // cosine threshold, signed Q1.15

  // Edges per triangle face; a face has as many vertices and normal components
  localparam int FACE_EDGES = 3;

  // Opcodes of the input word
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_NEXT  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic done;    // dot product finished this cycle
    logic crease;  // dot product is strictly below the scaled threshold
  } dot_status_t;

endpackage

`default_nettype wire

/* hw/rtl/cee_face_store.sv */
// Face store: vertex and normal memories, one write port and one read port
// each, read data registered. Depends on cee_pkg.
`default_nettype none

module cee_face_store #(
  parameter int MAX_FACES   = cee_pkg::MAX_FACES_DEF,
  parameter int VERTEX_BITS = cee_pkg::VERTEX_BITS_DEF,
  parameter int NORMAL_BITS = cee_pkg::NORMAL_BITS_DEF,
  localparam int ADDR_W     = $clog2(MAX_FACES)
) (
  input  logic                                                 clk,
  input  logic                                                 wr_en,
  input  logic [ADDR_W-1:0]                                    wr_addr,
  input  logic [cee_pkg::FACE_EDGES-1:0][VERTEX_BITS-1:0]      wr_vert,
  input  logic [cee_pkg::FACE_EDGES-1:0][NORMAL_BITS-1:0]      wr_norm,
  input  logic                                                 rd_en,
  input  logic [ADDR_W-1:0]                                    rd_addr,
  output logic [cee_pkg::FACE_EDGES-1:0][VERTEX_BITS-1:0]      rd_vert,
  output logic [cee_pkg::FACE_EDGES-1:0][NORMAL_BITS-1:0]      rd_norm
);

  logic [cee_pkg::FACE_EDGES-1:0][VERTEX_BITS-1:0] vert_mem [MAX_FACES];
  logic [cee_pkg::FACE_EDGES-1:0][NORMAL_BITS-1:0] norm_mem [MAX_FACES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vert_mem[wr_addr] <= wr_vert;
      norm_mem[wr_addr] <= wr_norm;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vert <= vert_mem[rd_addr];
      rd_norm <= norm_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cee_dot_unit.sv */
// Normal dot product, its three products through one shared multiplier,
// then a signed compare against the threshold scaled to the product
// format. Depends on cee_pkg.
`default_nettype none

module cee_dot_unit #(
  parameter int NORMAL_BITS = cee_pkg::NORMAL_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  logic [cee_pkg::FACE_EDGES-1:0][NORMAL_BITS-1:0] norm_a,
  input  logic [cee_pkg::FACE_EDGES-1:0][NORMAL_BITS-1:0] norm_b,
  input  logic [cee_pkg::THR_W-1:0]                       thr,
  output cee_pkg::dot_status_t                            status
);

  localparam int PROD_W = 2 * NORMAL_BITS;
  localparam int ACC_W  = PROD_W + 2;
  // Product fraction bits minus threshold fraction bits
  localparam int SH     = 2 * (NORMAL_BITS - 1) - (cee_pkg::THR_W - 1);
  localparam int SH_THR = (SH > 0) ? SH : 0;
  localparam int SH_DOT = (SH < 0) ? -SH : 0;
  localparam int CMP_W  = ((ACC_W + SH_DOT > cee_pkg::THR_W + SH_THR) ?
                           ACC_W + SH_DOT : cee_pkg::THR_W + SH_THR) + 1;
  localparam int STEP_W = $clog2(cee_pkg::FACE_EDGES + 1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(cee_pkg::FACE_EDGES);
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(1);

  logic                     busy;
  logic                     fin;
  logic [STEP_W-1:0]        step;
  logic [STEP_W-1:0]        lane;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [CMP_W-1:0]  dot_cmp;
  logic signed [CMP_W-1:0]  thr_cmp;

  assign lane     = (step < STEP_LAST) ? step : '0;
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      step <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_FIRST;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // Multiply one component per cycle; accumulate the registered product
  always_ff @(posedge clk) begin
    if (busy && step < STEP_LAST) begin
      prod <= $signed(norm_a[lane]) * $signed(norm_b[lane]);
    end
    if (busy && step != '0) begin
      acc <= ((step == STEP_FIRST) ? '0 : acc) + prod_ext;
    end
  end

  assign dot_cmp = {{(CMP_W - ACC_W){acc[ACC_W-1]}}, acc} <<< SH_DOT;
  assign thr_cmp = {{(CMP_W - cee_pkg::THR_W){thr[cee_pkg::THR_W-1]}}, thr} <<< SH_THR;

  assign status.done   = fin;
  assign status.crease = (dot_cmp < thr_cmp);

endmodule

`default_nettype wire

/* hw/rtl/crease_edge_extractor.sv */
// Crease edge extractor top level: command decode, scan sequencer and
// output register. Depends on cee_pkg, cee_face_store and cee_dot_unit.
`default_nettype none

// Faces go in one word at a time (opcode 1) and land in the face store, an
// on-chip memory of MAX_FACES entries; a load into a full store is dropped,
// answered by one word with load_overflow set, and the flag stays set until
// a clear (opcode 0). A request (opcode 2) resumes the scan where the last
// one stopped: every edge of face i, endpoints sorted, is compared with every
// edge of each later face, and at a shared edge the normal dot product is
// compared against cos_threshold. The request answers with exactly one word:
// either the next sharp edge or scan_done. Clear and load give no word
// (except a dropped load). For each (outer edge, later face) pair a request
// walks, it makes one read through the single read port of the face store
// and compares each of that face's edges; each shared edge found also runs
// the dot-product unit, which runs its three products through one multiplier.
// Write cos_threshold only while the block is idle; it resets to 0.
module crease_edge_extractor #(
  parameter int MAX_FACES   = cee_pkg::MAX_FACES_DEF,
  parameter int VERTEX_BITS = cee_pkg::VERTEX_BITS_DEF,
  parameter int NORMAL_BITS = cee_pkg::NORMAL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [cee_pkg::THR_W-1:0]   cfg_wr_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic [cee_pkg::PORT_W-1:0]  vertex_a,
  input  logic [cee_pkg::PORT_W-1:0]  vertex_b,
  input  logic [cee_pkg::PORT_W-1:0]  vertex_c,
  input  logic [cee_pkg::PORT_W-1:0]  normal_x,
  input  logic [cee_pkg::PORT_W-1:0]  normal_y,
  input  logic [cee_pkg::PORT_W-1:0]  normal_z,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        edge_valid,
  output logic [cee_pkg::PORT_W-1:0]  edge_low,
  output logic [cee_pkg::PORT_W-1:0]  edge_high,
  output logic                        scan_done,
  output logic                        load_overflow
);

  localparam int ADDR_W  = $clog2(MAX_FACES);
  // Face counters reach MAX_FACES + 1 (inner face just past a full store)
  localparam int CNT_W   = $clog2(MAX_FACES + 2);
  localparam int EDGES   = cee_pkg::FACE_EDGES;
  localparam int PW      = cee_pkg::PORT_W;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FACES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [1:0]       EDGE_LAST = 2'(EDGES - 1);
  localparam logic [1:0]       EDGE_STEP = 2'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RD_OUT = 3'd2;
  localparam logic [2:0] S_RD_IN  = 3'd3;
  localparam logic [2:0] S_DOT    = 3'd4;
  localparam logic [2:0] S_EDGE   = 3'd5;

  typedef logic [EDGES-1:0][VERTEX_BITS-1:0] vert_set_t;
  typedef logic [EDGES-1:0][NORMAL_BITS-1:0] norm_set_t;

  // Port value to stored vertex: truncate or zero-extend, as the port gives it
  function automatic logic [VERTEX_BITS-1:0] to_vert(input logic [PW-1:0] v);
    logic [VERTEX_BITS+PW-1:0] w;
    w = {{VERTEX_BITS{1'b0}}, v};
    return w[VERTEX_BITS-1:0];
  endfunction

  // Port value to stored normal: low NORMAL_BITS of the zero-extended field
  function automatic logic [NORMAL_BITS-1:0] to_norm(input logic [PW-1:0] v);
    logic [NORMAL_BITS+PW-1:0] w;
    w = {{NORMAL_BITS{1'b0}}, v};
    return w[NORMAL_BITS-1:0];
  endfunction

  function automatic logic [PW-1:0] to_port(input logic [VERTEX_BITS-1:0] v);
    logic [VERTEX_BITS+PW-1:0] w;
    w = {{PW{1'b0}}, v};
    return w[PW-1:0];
  endfunction

  // ------------------------------------------------------------------
  // State
  // ------------------------------------------------------------------
  logic [2:0]          state, state_next;
  logic [CNT_W-1:0]    face_count, face_count_next;
  logic [CNT_W-1:0]    outer_face, outer_face_next;
  logic [CNT_W-1:0]    inner_face, inner_face_next;
  logic [1:0]          outer_edge, outer_edge_next;
  logic [1:0]          inner_edge, inner_edge_next;
  logic                overflow_flag, overflow_flag_next;
  logic                outer_ok, outer_ok_next;   // outer face words are held
  logic                inner_ok, inner_ok_next;   // inner face words are held
  logic [cee_pkg::THR_W-1:0] cos_threshold;

  vert_set_t outer_vert, inner_vert;
  norm_set_t outer_norm, inner_norm;

  // Face store signals
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  vert_set_t         wr_vert, rd_vert;
  norm_set_t         wr_norm, rd_norm;

  // Dot unit
  logic                 dot_start;
  cee_pkg::dot_status_t dot_status;

  // Edge compare
  logic [VERTEX_BITS-1:0] o_a, o_b, i_a, i_b;
  logic [VERTEX_BITS-1:0] o_lo, o_hi, i_lo, i_hi;
  logic [1:0]             o_nxt, i_nxt;
  logic                   edge_hit;

  // Handshake and output control
  logic in_take;
  logic out_free;
  logic emit_done, emit_edge, emit_ovf;
  logic count_full;

  assign count_full = (face_count >= CNT_MAX);
  assign out_free   = !out_valid || !out_stall;

  // Take a word only when idle; a load into a full store needs the output
  // register free for its overflow word.
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall && count_full);
  assign in_take  = in_valid && !in_stall;

  assign wr_vert = {to_vert(vertex_c), to_vert(vertex_b), to_vert(vertex_a)};
  assign wr_norm = {to_norm(normal_z), to_norm(normal_y), to_norm(normal_x)};

  // Sorted endpoints of the current outer and inner edges
  always_comb begin
    o_nxt = (outer_edge == EDGE_LAST) ? '0 : outer_edge + EDGE_STEP;
    i_nxt = (inner_edge == EDGE_LAST) ? '0 : inner_edge + EDGE_STEP;
    o_a   = outer_vert[outer_edge];
    o_b   = outer_vert[o_nxt];
    i_a   = inner_vert[inner_edge];
    i_b   = inner_vert[i_nxt];
    o_lo  = (o_a > o_b) ? o_b : o_a;
    o_hi  = (o_a > o_b) ? o_a : o_b;
    i_lo  = (i_a > i_b) ? i_b : i_a;
    i_hi  = (i_a > i_b) ? i_a : i_b;
    edge_hit = (o_lo == i_lo) && (o_hi == i_hi);
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_next         = state;
    face_count_next    = face_count;
    outer_face_next    = outer_face;
    inner_face_next    = inner_face;
    outer_edge_next    = outer_edge;
    inner_edge_next    = inner_edge;
    overflow_flag_next = overflow_flag;
    outer_ok_next      = outer_ok;
    inner_ok_next      = inner_ok;
    wr_en              = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = outer_face[ADDR_W-1:0];
    dot_start          = 1'b0;
    emit_done          = 1'b0;
    emit_edge          = 1'b0;
    emit_ovf           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          unique case (opcode)
            cee_pkg::OP_CLEAR: begin
              face_count_next    = '0;
              outer_face_next    = '0;
              outer_edge_next    = '0;
              inner_face_next    = CNT_ONE;
              inner_edge_next    = '0;
              overflow_flag_next = 1'b0;
            end
            cee_pkg::OP_LOAD: begin
              if (count_full) begin
                overflow_flag_next = 1'b1;
                emit_ovf           = 1'b1;
              end else begin
                wr_en           = 1'b1;
                face_count_next = face_count + CNT_ONE;
              end
            end
            cee_pkg::OP_NEXT: begin
              // Reload both face words before the first compare
              outer_ok_next = 1'b0;
              inner_ok_next = 1'b0;
              state_next    = S_CHECK;
            end
            cee_pkg::OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      S_CHECK: begin
        if (outer_face >= face_count) begin
          // Scan exhausted: answer scan_done once the output register frees
          if (out_free) begin
            emit_done  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (inner_face >= face_count) begin
          // Advance the outer edge, and the outer face after its last edge
          if (outer_edge == EDGE_LAST) begin
            outer_edge_next = '0;
            outer_face_next = outer_face + CNT_ONE;
            inner_face_next = outer_face + CNT_TWO;
            outer_ok_next   = 1'b0;
          end else begin
            outer_edge_next = outer_edge + EDGE_STEP;
            inner_face_next = outer_face + CNT_ONE;
          end
          inner_edge_next = '0;
          inner_ok_next   = 1'b0;
        end else if (!outer_ok) begin
          rd_en      = 1'b1;
          rd_addr    = outer_face[ADDR_W-1:0];
          state_next = S_RD_OUT;
        end else if (!inner_ok) begin
          rd_en      = 1'b1;
          rd_addr    = inner_face[ADDR_W-1:0];
          state_next = S_RD_IN;
        end else begin
          // One edge pair a cycle between reads and dots; step past this pair
          if (inner_edge == EDGE_LAST) begin
            inner_edge_next = '0;
            inner_face_next = inner_face + CNT_ONE;
            inner_ok_next   = 1'b0;
          end else begin
            inner_edge_next = inner_edge + EDGE_STEP;
          end
          if (edge_hit) begin
            dot_start  = 1'b1;
            state_next = S_DOT;
          end
        end
      end

      S_RD_OUT: begin
        outer_ok_next = 1'b1;
        state_next    = S_CHECK;
      end

      S_RD_IN: begin
        inner_ok_next = 1'b1;
        state_next    = S_CHECK;
      end

      S_DOT: begin
        if (dot_status.done) begin
          state_next = dot_status.crease ? S_EDGE : S_CHECK;
        end
      end

      S_EDGE: begin
        // Outer words and outer_edge are unchanged since the match
        if (out_free) begin
          emit_edge  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      face_count    <= '0;
      outer_face    <= '0;
      inner_face    <= CNT_ONE;
      outer_edge    <= '0;
      inner_edge    <= '0;
      overflow_flag <= 1'b0;
      outer_ok      <= 1'b0;
      inner_ok      <= 1'b0;
      cos_threshold <= '0;
    end else begin
      state         <= state_next;
      face_count    <= face_count_next;
      outer_face    <= outer_face_next;
      inner_face    <= inner_face_next;
      outer_edge    <= outer_edge_next;
      inner_edge    <= inner_edge_next;
      overflow_flag <= overflow_flag_next;
      outer_ok      <= outer_ok_next;
      inner_ok      <= inner_ok_next;
      if (cfg_wr_en) begin
        cos_threshold <= cfg_wr_data;
      end
    end
  end

  // Latch face words in S_RD_OUT or S_RD_IN, the state after the read issue
  always_ff @(posedge clk) begin
    if (state == S_RD_OUT) begin
      outer_vert <= rd_vert;
      outer_norm <= rd_norm;
    end
    if (state == S_RD_IN) begin
      inner_vert <= rd_vert;
      inner_norm <= rd_norm;
    end
  end

  // ------------------------------------------------------------------
  // Output register: hold while stalled, drop valid once taken
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_done || emit_edge || emit_ovf) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_done || emit_edge || emit_ovf) begin
      edge_valid    <= emit_edge;
      edge_low      <= emit_edge ? to_port(o_lo) : '0;
      edge_high     <= emit_edge ? to_port(o_hi) : '0;
      scan_done     <= emit_done;
      load_overflow <= emit_ovf || overflow_flag;
    end
  end

  // ------------------------------------------------------------------
  // Submodules
  // ------------------------------------------------------------------
  cee_face_store #(
    .MAX_FACES   (MAX_FACES),
    .VERTEX_BITS (VERTEX_BITS),
    .NORMAL_BITS (NORMAL_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (face_count[ADDR_W-1:0]),
    .wr_vert (wr_vert),
    .wr_norm (wr_norm),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_vert (rd_vert),
    .rd_norm (rd_norm)
  );

  cee_dot_unit #(
    .NORMAL_BITS (NORMAL_BITS)
  ) u_dot (
    .clk    (clk),
    .rst    (rst),
    .start  (dot_start),
    .norm_a (outer_norm),
    .norm_b (inner_norm),
    .thr    (cos_threshold),
    .status (dot_status)
  );

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  a_inner_after_outer: assert property (@(posedge clk) disable iff (rst)
    inner_face > outer_face)
    else $error("inner face pointer not past outer face");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    face_count <= CNT_MAX)
    else $error("face count exceeds store depth");

  a_edge_sorted: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_valid |-> edge_low <= edge_high && !scan_done)
    else $error("emitted edge unsorted or marked done");

  a_dot_inputs_held: assert property (@(posedge clk) disable iff (rst)
    dot_start |-> outer_ok && inner_ok)
    else $error("dot product started without both face words");
`endif

endmodule

`default_nettype wire

/* sim/crease_edge_extractor_test.sv */
// Self-checking bench for crease_edge_extractor: drives clear, load, next-edge and
// unused words, predicts each answer word in a scoreboard class and compares it
// field by field. Depends on cee_pkg and the crease_edge_extractor RTL.
`default_nettype none

module crease_edge_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH    = cee_pkg::MAX_FACES_DEF;
  localparam int W              = cee_pkg::PORT_W;
  localparam int RANDOM_ITEMS   = 450;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int SETTLE_CYCLES  = 24;

  typedef enum logic [1:0] {
    OP_CLEAR     = cee_pkg::OP_CLEAR,
    OP_LOAD      = cee_pkg::OP_LOAD,
    OP_NEXT_EDGE = cee_pkg::OP_NEXT,
    OP_UNUSED    = cee_pkg::OP_NONE
  } op_t;

  // One word on the input channel
  typedef struct packed {
    op_t          opcode;
    logic [W-1:0] vertex_a;
    logic [W-1:0] vertex_b;
    logic [W-1:0] vertex_c;
    logic [W-1:0] normal_x;
    logic [W-1:0] normal_y;
    logic [W-1:0] normal_z;
  } face_word_t;

  // One word on the output channel
  typedef struct packed {
    logic         edge_valid;
    logic [W-1:0] edge_low;
    logic [W-1:0] edge_high;
    logic         scan_done;
    logic         load_overflow;
  } edge_word_t;

  // Mirror of the face store and scan position; predicts the answer to each accepted
  // word and checks the answers the block gives, oldest first.
  class crease_scoreboard;
    logic [3*W-1:0]      vtx_mem [STORE_DEPTH];
    logic [3*W-1:0]      nrm_mem [STORE_DEPTH];
    int unsigned         face_count;
    int unsigned         outer_face;
    int unsigned         outer_edge;
    int unsigned         inner_face;
    int unsigned         inner_edge;
    bit                  overflow_flag;
    bit                  scan_ended;
    logic signed [W-1:0] cos_thr;
    edge_word_t          expected_edges[$];
    int                  mismatches;

    function new();
      face_count    = 0;
      overflow_flag = 0;
      cos_thr       = '0;
      mismatches    = 0;
      restart_scan();
    endfunction

    function void restart_scan();
      outer_face = 0;
      outer_edge = 0;
      inner_face = 1;
      inner_edge = 0;
      scan_ended = 0;
    endfunction

    function void set_threshold(logic [W-1:0] value);
      cos_thr = value;
    endfunction

    // Queue one predicted answer behind the ones still pending
    function void expect_word(edge_word_t r);
      expected_edges.insert(expected_edges.size(), r);
    endfunction

    function void edge_ends(input int unsigned f, input int unsigned e,
                            output logic [W-1:0] lo, output logic [W-1:0] hi);
      logic [W-1:0] a;
      logic [W-1:0] b;
      a = vtx_mem[f][W*e +: W];
      b = vtx_mem[f][W*((e + 1) % cee_pkg::FACE_EDGES) +: W];
      if (a > b) begin
        lo = b;
        hi = a;
      end else begin
        lo = a;
        hi = b;
      end
    endfunction

    // Exact Q2.30 dot product against the threshold scaled up from Q1.15
    function bit is_sharp(int unsigned f1, int unsigned f2);
      longint dot;
      longint thr;
      logic signed [W-1:0] n1;
      logic signed [W-1:0] n2;
      dot = 0;
      for (int j = 0; j < 3; j++) begin
        n1 = nrm_mem[f1][W*j +: W];
        n2 = nrm_mem[f2][W*j +: W];
        dot += longint'(n1) * longint'(n2);
      end
      thr = longint'(cos_thr) * 64'sd32768;
      return dot < thr;
    endfunction

    function void predict_next_edge();
      edge_word_t   r;
      logic [W-1:0] lo1;
      logic [W-1:0] hi1;
      logic [W-1:0] lo2;
      logic [W-1:0] hi2;
      bit           hit;
      r = '0;
      r.load_overflow = overflow_flag;
      while (1) begin
        if (outer_face >= face_count) begin
          r.scan_done = 1'b1;
          expect_word(r);
          scan_ended = 1;
          return;
        end
        if (inner_face >= face_count) begin
          // move on to the next outer edge, restart the inner walk after it
          outer_edge++;
          if (outer_edge >= cee_pkg::FACE_EDGES) begin
            outer_edge = 0;
            outer_face++;
          end
          inner_face = outer_face + 1;
          inner_edge = 0;
          continue;
        end
        edge_ends(outer_face, outer_edge, lo1, hi1);
        edge_ends(inner_face, inner_edge, lo2, hi2);
        hit = (lo1 == lo2) && (hi1 == hi2) && is_sharp(outer_face, inner_face);
        inner_edge++;
        if (inner_edge >= cee_pkg::FACE_EDGES) begin
          inner_edge = 0;
          inner_face++;
        end
        if (hit) begin
          r.edge_valid = 1'b1;
          r.edge_low   = lo1;
          r.edge_high  = hi1;
          expect_word(r);
          return;
        end
      end
    endfunction

    function void note_word(face_word_t w);
      edge_word_t r;
      case (w.opcode)
        OP_CLEAR: begin
          face_count    = 0;
          overflow_flag = 0;
          restart_scan();
        end
        OP_LOAD: begin
          scan_ended = 0;
          if (face_count >= STORE_DEPTH) begin
            overflow_flag   = 1;
            r               = '0;
            r.load_overflow = 1'b1;
            expect_word(r);
          end else begin
            vtx_mem[face_count] = {w.vertex_c, w.vertex_b, w.vertex_a};
            nrm_mem[face_count] = {w.normal_z, w.normal_y, w.normal_x};
            face_count++;
          end
        end
        OP_NEXT_EDGE: predict_next_edge();
        default: ;
      endcase
    endfunction

    task report(string what, logic [W-1:0] got, logic [W-1:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task check_word(edge_word_t got);
      edge_word_t want;
      if (expected_edges.size() == 0) begin
        report("word with nothing expected", got.edge_low, '0);
        return;
      end
      want = expected_edges.pop_front();
      if (got.edge_valid !== want.edge_valid)
        report("edge_valid", W'(got.edge_valid), W'(want.edge_valid));
      if (got.edge_low !== want.edge_low)
        report("edge_low", got.edge_low, want.edge_low);
      if (got.edge_high !== want.edge_high)
        report("edge_high", got.edge_high, want.edge_high);
      if (got.scan_done !== want.scan_done)
        report("scan_done", W'(got.scan_done), W'(want.scan_done));
      if (got.load_overflow !== want.load_overflow)
        report("load_overflow", W'(got.load_overflow), W'(want.load_overflow));
    endtask
  endclass

  logic         clk;
  logic         rst         = 1'b1;
  logic         cfg_wr_en   = 1'b0;
  logic [W-1:0] cfg_wr_data = '0;
  logic         in_valid    = 1'b0;
  logic         in_stall;
  logic [1:0]   opcode      = '0;
  logic [W-1:0] vertex_a    = '0;
  logic [W-1:0] vertex_b    = '0;
  logic [W-1:0] vertex_c    = '0;
  logic [W-1:0] normal_x    = '0;
  logic [W-1:0] normal_y    = '0;
  logic [W-1:0] normal_z    = '0;
  logic         out_valid;
  logic         out_stall   = 1'b0;
  logic         edge_valid;
  logic [W-1:0] edge_low;
  logic [W-1:0] edge_high;
  logic         scan_done;
  logic         load_overflow;

  crease_scoreboard sb;
  bit               no_gaps     = 0;  // no input gaps, no output stalls while set
  int               sent_items  = 0;
  int               quiet_cycles = 0;
  edge_word_t       seen_word;

  crease_edge_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .edge_valid   (edge_valid),
    .edge_low     (edge_low),
    .edge_high    (edge_high),
    .scan_done    (scan_done),
    .load_overflow(load_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: check every accepted word, then pick the stall for the next edge.
  // Values read right after the edge are the ones the edge sampled.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        seen_word = '{edge_valid: edge_valid, edge_low: edge_low, edge_high: edge_high,
                      scan_done: scan_done, load_overflow: load_overflow};
        sb.check_word(seen_word);
      end
      out_stall <= !no_gaps && ($urandom_range(0, 99) < 16);
    end
  end

  // Count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  function automatic face_word_t make_word(op_t op, logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] c, logic [W-1:0] x,
                                           logic [W-1:0] y, logic [W-1:0] z);
    face_word_t w;
    w = '{opcode: op, vertex_a: a, vertex_b: b, vertex_c: c,
          normal_x: x, normal_y: y, normal_z: z};
    return w;
  endfunction

  function automatic logic [W-1:0] rand_field();
    return W'($urandom);
  endfunction

  // Normal component: an extreme, a small value or a full-range random one
  function automatic logic [W-1:0] rand_normal();
    case ($urandom_range(0, 4))
      0:       return 16'sd32767;
      1:       return -16'sd32768;
      2:       return W'($urandom_range(0, 64)) - W'(32);
      default: return W'($urandom);
    endcase
  endfunction

  // Face on a small vertex pool above base, so that neighboring faces share edges
  function automatic face_word_t mesh_face(logic [W-1:0] base, int pool);
    return make_word(OP_LOAD, base + W'($urandom_range(0, pool - 1)),
                     base + W'($urandom_range(0, pool - 1)),
                     base + W'($urandom_range(0, pool - 1)),
                     rand_normal(), rand_normal(), rand_normal());
  endfunction

  function automatic face_word_t random_word(op_t op);
    return make_word(op, rand_field(), rand_field(), rand_field(),
                     rand_field(), rand_field(), rand_field());
  endfunction

  // Offer one word, sometimes after a random gap, and wait until it is taken
  task automatic send_word(face_word_t w);
    if (!no_gaps && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= w.opcode;
    vertex_a <= w.vertex_a;
    vertex_b <= w.vertex_b;
    vertex_c <= w.vertex_c;
    normal_x <= w.normal_x;
    normal_y <= w.normal_y;
    normal_z <= w.normal_z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    if (w.opcode != OP_UNUSED) sent_items++;
  endtask

  task automatic send_face(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c,
                           logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
    send_word(make_word(OP_LOAD, a, b, c, x, y, z));
  endtask

  // Ask for edges until the scan reports done
  task automatic drain_scan();
    int guard;
    guard = 0;
    while (!sb.scan_ended && guard < 2000) begin
      send_word(random_word(OP_NEXT_EDGE));
      guard++;
    end
  endtask

  // Drop valid, wait for every expected word, then let the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (sb.expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_threshold(value);
  endtask

  initial begin
    logic [W-1:0] base;
    int           n_faces;
    int           pool;
    int           pick;

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty store: the first request answers done at once
    send_word(random_word(OP_NEXT_EDGE));

    // Threshold 0 from reset. Faces 0/1 share edge 1-2 with opposite normals;
    // faces 2/3 are degenerate and share their repeated edges at the field extremes.
    send_face(16'd0, 16'd1, 16'd2, 16'sd32767, 16'sd0, 16'sd0);
    send_face(16'd2, 16'd1, 16'hffff, -16'sd32768, 16'sd0, 16'sd0);
    send_face(16'hffff, 16'hffff, 16'd0, -16'sd32768, -16'sd32768, -16'sd32768);
    send_face(16'd0, 16'hffff, 16'hffff, 16'sd32767, 16'sd32767, 16'sd32767);
    send_word(random_word(OP_NEXT_EDGE));
    send_word(make_word(OP_UNUSED, '1, '1, '1, '1, '1, '1));
    send_word(random_word(OP_NEXT_EDGE));
    // Load mid-scan: it joins the running scan. Zero normal makes the dot equal
    // the threshold, which must not count as sharp.
    send_face(16'd1, 16'd0, 16'd7, 16'sd0, 16'sd0, 16'sd0);
    drain_scan();
    send_word(random_word(OP_NEXT_EDGE));
    send_word(random_word(OP_CLEAR));
    send_word(random_word(OP_NEXT_EDGE));

    // Highest threshold: two equal unit normals fall just below it
    settle_block();
    write_threshold(16'sd32767);
    send_face(16'd5, 16'd6, 16'd7, 16'sd32767, 16'sd0, 16'sd0);
    send_face(16'd7, 16'd6, 16'd8, 16'sd32767, 16'sd0, 16'sd0);
    drain_scan();

    // Lowest threshold: only a dot below -1.0 is sharp
    settle_block();
    write_threshold(-16'sd32768);
    send_word(random_word(OP_CLEAR));
    send_face(16'd5, 16'd6, 16'd7, -16'sd32768, -16'sd32768, -16'sd32768);
    send_face(16'd6, 16'd5, 16'd9, -16'sd32768, -16'sd32768, -16'sd32768);
    send_face(16'd6, 16'd7, 16'd9, 16'sd32767, 16'sd32767, 16'sd32767);
    drain_scan();

    // Full store: fill every entry, overrun it twice, then one request that hits
    // on the very first pair so it never walks the big store.
    settle_block();
    write_threshold(16'sd0);
    send_word(random_word(OP_CLEAR));
    send_face(16'd10, 16'd11, 16'd12, 16'sd32767, 16'sd0, 16'sd0);
    send_face(16'd11, 16'd10, 16'd13, -16'sd32768, 16'sd0, 16'sd0);
    for (int k = 2; k < STORE_DEPTH; k++)
      send_word(random_word(OP_LOAD));
    send_word(random_word(OP_LOAD));
    send_word(random_word(OP_LOAD));
    send_word(random_word(OP_NEXT_EDGE));
    send_word(random_word(OP_CLEAR));
    send_word(random_word(OP_NEXT_EDGE));

    // Random meshes: each phase picks a threshold, loads a small mesh with some
    // requests and noise mixed in, then walks the scan to its end.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      settle_block();
      no_gaps = (sent_items >= 180) && (sent_items < 280);
      case ($urandom_range(0, 5))
        0:       write_threshold(-16'sd32768);
        1:       write_threshold(16'sd32767);
        2:       write_threshold(16'sd0);
        default: write_threshold(rand_field());
      endcase
      // Keep the store small so a full scan stays cheap
      if (sb.face_count > 6 || $urandom_range(0, 99) < 85)
        send_word(random_word(OP_CLEAR));
      n_faces = $urandom_range(2, 10);
      pool    = $urandom_range(3, n_faces + 3);
      base    = rand_field();
      for (int k = 0; k < n_faces; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6)
          send_word(random_word(OP_UNUSED));
        else if (pick < 18)
          send_word(random_word(OP_NEXT_EDGE));
        else if (pick < 26)
          send_word(random_word(OP_LOAD));
        send_word(mesh_face(base, pool));
      end
      drain_scan();
      if ($urandom_range(0, 1) == 1)
        send_word(random_word(OP_NEXT_EDGE));
    end
    no_gaps = 0;

    settle_block();
    if (sb.mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
